FILE: rtl/core/aes128_pkg.sv
// Package for the AES-128 block cipher unit.
// Types, S-box tables and round functions; no dependencies.
package aes128_pkg;

  typedef struct packed {
    logic        mode;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_item_t;

  localparam logic CFG_KEY_HIGH = 1'b0;
  localparam logic CFG_KEY_LOW  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_DECKEY,
    ST_LOAD,
    ST_ROUND,
    ST_DONE
  } state_e;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'd99,8'd124,8'd119,8'd123,8'd242,8'd107,8'd111,8'd197,8'd48,8'd1,8'd103,8'd43,
      8'd254,8'd215,8'd171,8'd118,8'd202,8'd130,8'd201,8'd125,8'd250,8'd89,8'd71,8'd240,
      8'd173,8'd212,8'd162,8'd175,8'd156,8'd164,8'd114,8'd192,8'd183,8'd253,8'd147,8'd38,
      8'd54,8'd63,8'd247,8'd204,8'd52,8'd165,8'd229,8'd241,8'd113,8'd216,8'd49,8'd21,
      8'd4,8'd199,8'd35,8'd195,8'd24,8'd150,8'd5,8'd154,8'd7,8'd18,8'd128,8'd226,
      8'd235,8'd39,8'd178,8'd117,8'd9,8'd131,8'd44,8'd26,8'd27,8'd110,8'd90,8'd160,
      8'd82,8'd59,8'd214,8'd179,8'd41,8'd227,8'd47,8'd132,8'd83,8'd209,8'd0,8'd237,
      8'd32,8'd252,8'd177,8'd91,8'd106,8'd203,8'd190,8'd57,8'd74,8'd76,8'd88,8'd207,
      8'd208,8'd239,8'd170,8'd251,8'd67,8'd77,8'd51,8'd133,8'd69,8'd249,8'd2,8'd127,
      8'd80,8'd60,8'd159,8'd168,8'd81,8'd163,8'd64,8'd143,8'd146,8'd157,8'd56,8'd245,
      8'd188,8'd182,8'd218,8'd33,8'd16,8'd255,8'd243,8'd210,8'd205,8'd12,8'd19,8'd236,
      8'd95,8'd151,8'd68,8'd23,8'd196,8'd167,8'd126,8'd61,8'd100,8'd93,8'd25,8'd115,
      8'd96,8'd129,8'd79,8'd220,8'd34,8'd42,8'd144,8'd136,8'd70,8'd238,8'd184,8'd20,
      8'd222,8'd94,8'd11,8'd219,8'd224,8'd50,8'd58,8'd10,8'd73,8'd6,8'd36,8'd92,
      8'd194,8'd211,8'd172,8'd98,8'd145,8'd149,8'd228,8'd121,8'd231,8'd200,8'd55,8'd109,
      8'd141,8'd213,8'd78,8'd169,8'd108,8'd86,8'd244,8'd234,8'd101,8'd122,8'd174,8'd8,
      8'd186,8'd120,8'd37,8'd46,8'd28,8'd166,8'd180,8'd198,8'd232,8'd221,8'd116,8'd31,
      8'd75,8'd189,8'd139,8'd138,8'd112,8'd62,8'd181,8'd102,8'd72,8'd3,8'd246,8'd14,
      8'd97,8'd53,8'd87,8'd185,8'd134,8'd193,8'd29,8'd158,8'd225,8'd248,8'd152,8'd17,
      8'd105,8'd217,8'd142,8'd148,8'd155,8'd30,8'd135,8'd233,8'd206,8'd85,8'd40,8'd223,
      8'd140,8'd161,8'd137,8'd13,8'd191,8'd230,8'd66,8'd104,8'd65,8'd153,8'd45,8'd15,
      8'd176,8'd84,8'd187,8'd22};
    return t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] r;
    r = 8'd0;
    for (int i = 0; i < 256; i++) begin
      if (sbox(8'(i)) == a) r = 8'(i);
    end
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m2 [4];
    logic [7:0] m3 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [31:0] r;
    for (int i = 0; i < 4; i++) begin
      a[i]  = c[31-8*i -: 8];
      x2[i] = xtime(a[i]);
      x4[i] = xtime(x2[i]);
      x8[i] = xtime(x4[i]);
      m2[i] = x2[i];
      m3[i] = x2[i] ^ a[i];
      m9[i] = x8[i] ^ a[i];
      mb[i] = x8[i] ^ x2[i] ^ a[i];
      md[i] = x8[i] ^ x4[i] ^ a[i];
      me[i] = x8[i] ^ x4[i] ^ x2[i];
    end
    for (int i = 0; i < 4; i++) begin
      if (inv) begin
        r[31-8*i -: 8] = me[i] ^ mb[(i+1)%4] ^ md[(i+2)%4] ^ m9[(i+3)%4];
      end else begin
        r[31-8*i -: 8] = m2[i] ^ m3[(i+1)%4] ^ a[(i+2)%4] ^ a[(i+3)%4];
      end
    end
    return r;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s, input logic inv);
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      r[127-32*c -: 32] = mix_col(s[127-32*c -: 32], inv);
    end
    return r;
  endfunction

  function automatic logic [127:0] round_fn(input logic [127:0] s, input logic inv,
                                            input logic last);
    logic [127:0] t;
    logic [7:0] b;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          b = s[127-8*(r+4*((c+4-r)%4)) -: 8];
          t[127-8*(r+4*c) -: 8] = inv_sbox(b);
        end else begin
          b = s[127-8*(r+4*((c+r)%4)) -: 8];
          t[127-8*(r+4*c) -: 8] = sbox(b);
        end
      end
    end
    return last ? t : mix_cols(t, inv);
  endfunction

endpackage

FILE: rtl/core/aes128_keymem.sv
// Round key store: encrypt and decrypt key sets in one synchronous memory.
// Depends on aes128_pkg; entry = 128-bit round key, registered read port.
module aes128_keymem #(
  parameter int DEPTH = 22,
  parameter int AW    = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [127:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [127:0]  rdata_o
);
  import aes128_pkg::*;

  logic [127:0] mem [DEPTH];
  logic [127:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

FILE: rtl/core/aes128_block_cipher_unit.sv
// AES-128 encrypt/decrypt unit.
// Usage: write key_high (index 0) and key_low (index 1) via cfg_we_i while idle.
// Input transaction: mode (0 enc, 1 dec) and the 128-bit block on in_data_i.
// Output transaction: the 128-bit result on out_data_o, one per input.
// Round keys live in a 22-entry x 128-bit memory (encrypt keys at 0..10,
// decrypt keys at 11..21) read once per round through its registered port.
// Each block passes through a read setup, the initial key add, ten rounds
// and an output load, one round per cycle through the shared round unit.
// After reset or a key write, the first block first runs key expansion
// (one round key per cycle); the first decrypt after that also builds the
// inverse keys (read then write per key).
// Reset clears the ready flags and the output valid; key memory is not cleared.
// A stalled receiver holds the result in the output register; the next
// transaction is accepted only once the result has been taken.
module aes128_block_cipher_unit #(
  parameter int ROUNDS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [63:0]           cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  aes128_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output aes128_pkg::out_item_t out_data_o
);
  import aes128_pkg::*;

  localparam int NK = ROUNDS + 1;
  localparam int AW = $clog2(2 * NK);

  state_e state_q, state_d;
  logic [63:0] key_hi_q, key_lo_q;
  logic enc_rdy_q, enc_rdy_d, dec_rdy_q, dec_rdy_d;
  logic mode_q, mode_d;
  logic [127:0] st_q, st_d;
  logic [127:0] wk_q, wk_d;
  logic [7:0] rc_q, rc_d;
  logic [4:0] cnt_q, cnt_d;
  logic phase_q, phase_d;
  logic ov_q, ov_d;
  out_item_t od_q, od_d;

  logic km_we;
  logic [AW-1:0] km_wa, km_ra;
  logic [127:0] km_wd, km_rd;

  aes128_keymem #(
    .DEPTH(2 * NK),
    .AW   (AW)
  ) u_keymem (
    .clk_i  (clk_i),
    .we_i   (km_we),
    .waddr_i(km_wa),
    .wdata_i(km_wd),
    .raddr_i(km_ra),
    .rdata_o(km_rd)
  );

  logic [31:0] tw;
  logic [127:0] nk;

  always_comb begin
    tw = {sbox(wk_q[23:16]), sbox(wk_q[15:8]), sbox(wk_q[7:0]), sbox(wk_q[31:24])}
         ^ {rc_q, 24'd0};
    nk[127:96] = wk_q[127:96] ^ tw;
    nk[95:64]  = wk_q[95:64] ^ nk[127:96];
    nk[63:32]  = wk_q[63:32] ^ nk[95:64];
    nk[31:0]   = wk_q[31:0] ^ nk[63:32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      enc_rdy_q <= 1'b0;
      dec_rdy_q <= 1'b0;
      ov_q      <= 1'b0;
      cnt_q     <= '0;
      phase_q   <= 1'b0;
      key_hi_q  <= '0;
      key_lo_q  <= '0;
    end else begin
      state_q   <= state_d;
      enc_rdy_q <= enc_rdy_d;
      dec_rdy_q <= dec_rdy_d;
      ov_q      <= ov_d;
      cnt_q     <= cnt_d;
      phase_q   <= phase_d;
      if (cfg_we_i && cfg_index_i == CFG_KEY_HIGH) key_hi_q <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == CFG_KEY_LOW)  key_lo_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    st_q   <= st_d;
    wk_q   <= wk_d;
    rc_q   <= rc_d;
    od_q   <= od_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE) && !ov_q;
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  always_comb begin
    state_d   = state_q;
    enc_rdy_d = enc_rdy_q;
    dec_rdy_d = dec_rdy_q;
    mode_d    = mode_q;
    st_d      = st_q;
    wk_d      = wk_q;
    rc_d      = rc_q;
    cnt_d     = cnt_q;
    phase_d   = phase_q;
    ov_d      = ov_q;
    od_d      = od_q;
    km_we     = 1'b0;
    km_wa     = '0;
    km_wd     = wk_q;
    km_ra     = '0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          mode_d = in_data_i.mode;
          st_d   = {in_data_i.block_high, in_data_i.block_low};
          cnt_d  = '0;
          if (!enc_rdy_q) begin
            wk_d    = {key_hi_q, key_lo_q};
            rc_d    = 8'h01;
            dec_rdy_d = 1'b0;
            state_d = ST_EXPAND;
          end else if (in_data_i.mode && !dec_rdy_q) begin
            phase_d = 1'b0;
            state_d = ST_DECKEY;
          end else begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_EXPAND: begin
        km_we = 1'b1;
        km_wa = AW'(cnt_q);
        km_wd = wk_q;
        wk_d  = nk;
        rc_d  = xtime(rc_q);
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(ROUNDS)) begin
          enc_rdy_d = 1'b1;
          cnt_d     = '0;
          phase_d   = 1'b0;
          state_d   = mode_q ? ST_DECKEY : ST_LOAD;
        end
      end
      ST_DECKEY: begin
        // phase 0: read enc key ROUNDS-cnt; phase 1: write dec key cnt
        if (!phase_q) begin
          km_ra   = AW'(5'(ROUNDS) - cnt_q);
          phase_d = 1'b1;
        end else begin
          km_we   = 1'b1;
          km_wa   = AW'(cnt_q + 5'(NK));
          km_wd   = (cnt_q == '0 || cnt_q == 5'(ROUNDS)) ? km_rd : mix_cols(km_rd, 1'b1);
          phase_d = 1'b0;
          cnt_d   = cnt_q + 5'd1;
          if (cnt_q == 5'(ROUNDS)) begin
            dec_rdy_d = 1'b1;
            cnt_d     = '0;
            state_d   = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        km_ra   = mode_q ? AW'(NK) : '0;
        cnt_d   = '0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        if (cnt_q != 5'(ROUNDS)) km_ra = AW'((mode_q ? 5'(NK) : 5'd0) + cnt_q + 5'd1);
        if (cnt_q == '0) st_d = st_q ^ km_rd;
        else st_d = round_fn(st_q, mode_q, cnt_q == 5'(ROUNDS)) ^ km_rd;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(ROUNDS)) state_d = ST_DONE;
      end
      ST_DONE: begin
        ov_d    = 1'b1;
        od_d    = st_q;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (cfg_we_i) begin
      enc_rdy_d = 1'b0;
      dec_rdy_d = 1'b0;
    end
  end
endmodule

FILE: rtl/core/aes128_checker.sv
// Port-level checker for the AES-128 unit, bound to the top level.
// Depends on aes128_pkg for the payload types.
module aes128_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input aes128_pkg::out_item_t out_data_o
);
  import aes128_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped under stall");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while result pending");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o ##1 !out_valid_o)
    else $error("result too early");

  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction accepted while busy");
endmodule

bind aes128_block_cipher_unit aes128_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
